### rtl/smmh_pkg.sv
// ----------------------------------------------------------------------------
// smmh_pkg: shared types and constants for the symmetric min-max heap unit
// Holds the command and status codes, the default slot count and the
// state type of the command sequencer.
// ----------------------------------------------------------------------------
package smmh_pkg;

	localparam int HEAP_SLOTS_DEF = 1024;
	localparam int KEY_W = 32;
	localparam int COUNT_W = 10;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DEL_MIN = 2'd1,
		CMD_DEL_MAX = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INS_RD,    // read sibling pos-1 (odd pos)
		S_INS_SIB,   // compare against sibling
		S_INS_GRD,   // read grandparent lo
		S_INS_GLO,   // lo data back, read hi
		S_INS_GHI,   // hi data back, decide
		S_INS_PUT,   // write key at pos
		S_DEL_RDL,   // read last entry
		S_DEL_LST,   // last entry back
		S_DEL_RDP,   // read partner slot
		S_DEL_PRT,   // partner back
		S_DEL_RC1,   // read c1
		S_DEL_C1,    // c1 back, read c2
		S_DEL_C2,    // c2 back
		S_DEL_DEC,   // decide move
		S_RPT_RD2,   // read slot 2
		S_RPT_RD3,   // slot 2 back, read slot 3
		S_RPT_OUT    // slot 3 back, report
	} state_t;

endpackage

### rtl/symmetric_min_max_heap_unit.sv
// ----------------------------------------------------------------------------
// symmetric_min_max_heap_unit: double-ended priority queue of signed keys
// Keys sit in a single-port synchronous memory, slots 2 to count+1.
// ----------------------------------------------------------------------------
// Usage: pulse start with command and key while busy is low. The unit raises
// busy, walks the heap in memory one level at a time and then drives status,
// count, min_key and max_key for exactly one cycle with done high; the result
// must be taken in that cycle since it cannot be held off. An insert at an odd
// slot first checks its sibling; an insert then climbs level by level against
// the grandparent pair and places the key. A delete fetches the last entry and
// sifts it down level by level, reading the partner slot and both children.
// Both then read back the minimum and maximum from slots 2 and 3 through the
// single memory port, which has a registered read. No clearing pass is needed.
module symmetric_min_max_heap_unit #(
	parameter int HEAP_SLOTS = smmh_pkg::HEAP_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    command,
	input  logic signed [smmh_pkg::KEY_W-1:0] key,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [smmh_pkg::COUNT_W-1:0]  count,
	output logic signed [smmh_pkg::KEY_W-1:0] min_key,
	output logic signed [smmh_pkg::KEY_W-1:0] max_key
);
	import smmh_pkg::*;

	localparam int AW = $clog2(HEAP_SLOTS);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] CAP = CW'(HEAP_SLOTS - 2);

	// heap memory, one port, registered read
	logic signed [KEY_W-1:0] mem [HEAP_SLOTS];
	logic [AW-1:0] m_addr;
	logic m_we;
	logic signed [KEY_W-1:0] m_wd;
	logic signed [KEY_W-1:0] m_rd;

	always_ff @(posedge clk) begin
		if (m_we) mem[m_addr] <= m_wd;
		m_rd <= mem[m_addr];
	end

	state_t state_q, state_n;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pos_q, c_q, last_q;
	logic signed [KEY_W-1:0] y_q, cv_q, mn_q;
	logic tmax_q, have_q;
	logic [1:0] st_q;

	// derived addresses
	logic [CW-1:0] gp_lo, c1, c2;
	always_comb begin
		gp_lo = (pos_q >> 2) << 1;
		c1 = tmax_q ? (((pos_q - 1'b1) << 1) + 1'b1) : (pos_q << 1);
		c2 = tmax_q ? ((pos_q << 1) + 1'b1) : ((pos_q + 1'b1) << 1);
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: if (start) begin
				if (command == CMD_INSERT && cnt_q < CAP)
					state_n = cnt_q[0] ? S_INS_RD : S_INS_GRD;
				else if ((command == CMD_DEL_MIN || command == CMD_DEL_MAX) && cnt_q != '0)
					state_n = S_DEL_RDL;
				else state_n = S_RPT_RD2;
			end
			S_INS_RD: state_n = S_INS_SIB;
			S_INS_SIB: state_n = S_INS_GRD;
			S_INS_GRD: state_n = (pos_q >= CW'(4)) ? S_INS_GLO : S_INS_PUT;
			S_INS_GLO: state_n = (y_q < m_rd) ? S_INS_GRD : S_INS_GHI;
			S_INS_GHI: state_n = (m_rd < y_q) ? S_INS_GRD : S_INS_PUT;
			S_INS_PUT: state_n = S_RPT_RD2;
			S_DEL_RDL: state_n = S_DEL_LST;
			S_DEL_LST: state_n = (pos_q > last_q) ? S_RPT_RD2 : S_DEL_RDP;
			S_DEL_RDP: state_n = S_DEL_PRT;
			S_DEL_PRT: state_n = S_DEL_RC1;
			S_DEL_RC1: state_n = S_DEL_C1;
			S_DEL_C1: state_n = S_DEL_C2;
			S_DEL_C2: state_n = S_DEL_DEC;
			S_DEL_DEC: state_n = (have_q && (tmax_q ? (y_q < cv_q) : (cv_q < y_q)))
				? S_DEL_RDP : S_RPT_RD2;
			S_RPT_RD2: state_n = S_RPT_RD3;
			S_RPT_RD3: state_n = S_RPT_OUT;
			S_RPT_OUT: state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// memory port and outputs
	always_comb begin
		m_addr = '0;
		m_we = 1'b0;
		m_wd = y_q;
		unique case (state_q)
			S_INS_RD: m_addr = AW'(pos_q - 1'b1);
			S_INS_SIB: if (y_q < m_rd) begin
				m_we = 1'b1; m_addr = AW'(pos_q); m_wd = m_rd;
			end
			S_INS_GRD: m_addr = AW'(gp_lo);
			S_INS_GLO: if (y_q < m_rd) begin
				m_we = 1'b1; m_addr = AW'(pos_q); m_wd = m_rd;
			end else m_addr = AW'(gp_lo + 1'b1);
			S_INS_GHI: if (m_rd < y_q) begin
				m_we = 1'b1; m_addr = AW'(pos_q); m_wd = m_rd;
			end
			S_INS_PUT: begin m_we = 1'b1; m_addr = AW'(pos_q); end
			// count already dropped by one: last entry sits at count+2
			S_DEL_RDL: m_addr = AW'(cnt_q + CW'(2));
			S_DEL_RDP: m_addr = AW'(tmax_q ? pos_q - 1'b1 : pos_q + 1'b1);
			S_DEL_PRT: begin
				m_addr = AW'(tmax_q ? pos_q - 1'b1 : pos_q + 1'b1);
				if (tmax_q ? (y_q < m_rd) : ((pos_q + 1'b1 <= last_q) && (m_rd < y_q)))
					m_we = 1'b1;
			end
			S_DEL_RC1: m_addr = AW'(c1);
			S_DEL_C1: m_addr = AW'(c2);
			S_DEL_DEC: begin
				m_addr = AW'(pos_q);
				m_we = 1'b1;
				if (have_q && (tmax_q ? (y_q < cv_q) : (cv_q < y_q))) m_wd = cv_q;
			end
			S_RPT_RD2: m_addr = AW'(2);
			S_RPT_RD3: m_addr = AW'(3);
			default: ;
		endcase
	end

	always_comb begin
		busy = (state_q != S_IDLE);
		done = (state_q == S_RPT_OUT);
		status = st_q;
		count = COUNT_W'(cnt_q);
		min_key = (cnt_q == '0) ? '0 : mn_q;
		max_key = (cnt_q == '0) ? '0 : (cnt_q == CW'(1)) ? mn_q : m_rd;
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			st_q <= ST_DONE;
		end else begin
			state_q <= state_n;
			if (state_q == S_IDLE && start) begin
				st_q <= ST_DONE;
				if (command == CMD_INSERT) begin
					if (cnt_q < CAP) cnt_q <= cnt_q + 1'b1;
					else st_q <= ST_FULL;
				end else if (command == CMD_DEL_MIN || command == CMD_DEL_MAX) begin
					if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
					else st_q <= ST_EMPTY;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				y_q <= key;
				pos_q <= cnt_q + CW'(2);
				tmax_q <= (command == CMD_DEL_MAX);
				last_q <= cnt_q;
			end
			S_INS_SIB: if (y_q < m_rd) pos_q <= pos_q - 1'b1;
			S_INS_GLO: begin
				if (y_q < m_rd) pos_q <= gp_lo;
			end
			S_INS_GHI: if (m_rd < y_q) pos_q <= gp_lo + 1'b1;
			S_DEL_RDL: pos_q <= tmax_q ? CW'(3) : CW'(2);
			S_DEL_LST: y_q <= m_rd;
			S_DEL_PRT: if (tmax_q ? (y_q < m_rd) : ((pos_q + 1'b1 <= last_q) && (m_rd < y_q)))
				y_q <= m_rd;
			S_DEL_C1: begin
				have_q <= (c1 <= last_q);
				c_q <= c1;
				cv_q <= m_rd;
			end
			S_DEL_C2: if (c2 <= last_q) begin
				if (!have_q || (tmax_q ? (cv_q < m_rd) : (m_rd < cv_q))) begin
					c_q <= c2; cv_q <= m_rd;
				end
				have_q <= 1'b1;
			end
			S_DEL_DEC: pos_q <= c_q;
			S_RPT_RD3: mn_q <= m_rd;
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_cap: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CAP)
		else $error("count beyond capacity");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result held more than one cycle");
	a_cnt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |-> $stable(cnt_q))
		else $error("count moved mid command");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> cnt_q == CAP)
		else $error("full flag without full heap");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the symmetric min-max heap unit
// Drives insert, delete and unused-code items through the start/busy handshake,
// predicts every report with a behavioral copy of the heap and checks each done
// strobe field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
	import smmh_pkg::*;

	localparam int SLOTS = 1024;
	localparam int CAPACITY = SLOTS - 2;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		status_t status;
		logic [COUNT_W-1:0] count;
		logic signed [KEY_W-1:0] min_key;
		logic signed [KEY_W-1:0] max_key;
	} report_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] command;
	logic signed [KEY_W-1:0] key;
	logic done;
	logic [1:0] status;
	logic [COUNT_W-1:0] count;
	logic signed [KEY_W-1:0] min_key;
	logic signed [KEY_W-1:0] max_key;

	// behavioral heap: keys in slots 2 .. held+1
	logic signed [KEY_W-1:0] shadow_heap [SLOTS];
	int unsigned held;
	report_t pending_reports[$];
	int unsigned failures;

	symmetric_min_max_heap_unit #(.HEAP_SLOTS(SLOTS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.key(key),
		.done(done),
		.status(status),
		.count(count),
		.min_key(min_key),
		.max_key(max_key)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// ------------------------------------------------------------------------
	// heap predictor
	// ------------------------------------------------------------------------
	function automatic void heap_push(logic signed [KEY_W-1:0] y);
		int unsigned pos;
		int unsigned lo;
		held++;
		pos = held + 1;
		// odd slot is the max side of its pair: swap with the min side if smaller
		if (pos[0] && y < shadow_heap[pos-1]) begin
			shadow_heap[pos] = shadow_heap[pos-1];
			pos--;
		end
		// climb against the grandparent's pair
		while (pos >= 4) begin
			lo = 2 * (pos >> 2);
			if (y < shadow_heap[lo]) begin
				shadow_heap[pos] = shadow_heap[lo];
				pos = lo;
			end else if (shadow_heap[lo+1] < y) begin
				shadow_heap[pos] = shadow_heap[lo+1];
				pos = lo + 1;
			end else begin
				break;
			end
		end
		shadow_heap[pos] = y;
	endfunction

	function automatic void heap_pop(bit take_max);
		logic signed [KEY_W-1:0] y;
		logic signed [KEY_W-1:0] t;
		int unsigned pos;
		int unsigned last;
		int unsigned c1;
		int unsigned c2;
		int unsigned c;
		bit have;
		y = shadow_heap[held+1];
		pos = take_max ? 3 : 2;
		held--;
		last = held + 1;
		if (pos > last)
			return;
		forever begin
			have = 1'b0;
			if (!take_max) begin
				if (pos + 1 <= last && shadow_heap[pos+1] < y) begin
					t = shadow_heap[pos+1];
					shadow_heap[pos+1] = y;
					y = t;
				end
				c1 = 2 * pos;
				c2 = 2 * (pos + 1);
			end else begin
				if (y < shadow_heap[pos-1]) begin
					t = shadow_heap[pos-1];
					shadow_heap[pos-1] = y;
					y = t;
				end
				c1 = 2 * (pos - 1) + 1;
				c2 = 2 * pos + 1;
			end
			c = 0;
			if (c1 <= last) begin
				c = c1;
				have = 1'b1;
			end
			if (c2 <= last) begin
				if (!have) begin
					c = c2;
					have = 1'b1;
				end else if (take_max ? (shadow_heap[c] < shadow_heap[c2])
						: (shadow_heap[c2] < shadow_heap[c])) begin
					c = c2;
				end
			end
			if (have && (take_max ? (y < shadow_heap[c]) : (shadow_heap[c] < y))) begin
				shadow_heap[pos] = shadow_heap[c];
				pos = c;
			end else begin
				shadow_heap[pos] = y;
				return;
			end
		end
	endfunction

	function automatic report_t heap_apply(cmd_t cmd, logic signed [KEY_W-1:0] k);
		report_t r;
		r = '0;
		r.status = ST_DONE;
		case (cmd)
			CMD_INSERT: begin
				if (held >= CAPACITY)
					r.status = ST_FULL;
				else
					heap_push(k);
			end
			CMD_DEL_MIN, CMD_DEL_MAX: begin
				if (held == 0)
					r.status = ST_EMPTY;
				else
					heap_pop(cmd == CMD_DEL_MAX);
			end
			default: ;
		endcase
		r.count = held[COUNT_W-1:0];
		if (held == 1) begin
			r.min_key = shadow_heap[2];
			r.max_key = shadow_heap[2];
		end else if (held >= 2) begin
			r.min_key = shadow_heap[2];
			r.max_key = shadow_heap[3];
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// report checker: the unit cannot stall, so check every done strobe
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		report_t exp_r;
		if (arst_n && done) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected report: status %0d count %0d", status, count);
				failures++;
			end else begin
				exp_r = pending_reports.pop_front();
				if (status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, status);
					failures++;
				end
				if (count !== exp_r.count) begin
					$error("count: expected %0d, got %0d", exp_r.count, count);
					failures++;
				end
				if (min_key !== exp_r.min_key) begin
					$error("min_key: expected %0d, got %0d", exp_r.min_key, min_key);
					failures++;
				end
				if (max_key !== exp_r.max_key) begin
					$error("max_key: expected %0d, got %0d", exp_r.max_key, max_key);
					failures++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// item driver
	// ------------------------------------------------------------------------
	// hold start low for a random gap: mostly none, sometimes short, rarely long
	task automatic idle_gap();
		int unsigned pick;
		int unsigned n;
		pick = $urandom_range(99);
		if (pick < 55)
			n = 0;
		else if (pick < 90)
			n = $urandom_range(3, 1);
		else
			n = $urandom_range(60, 10);
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// send one item: start stays high back to back when no gap is taken
	task automatic send_item(cmd_t cmd, logic signed [KEY_W-1:0] k);
		idle_gap();
		start <= 1'b1;
		command <= cmd;
		key <= k;
		do
			@(posedge clk);
		while (busy);
		pending_reports.push_back(heap_apply(cmd, k));
	endtask

	task automatic quiesce();
		start <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(8)) - 4;     // many ties
			2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(2000)) - 1000;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_corner_items();
		send_item(CMD_DEL_MIN, '0);             // delete when empty
		send_item(CMD_DEL_MAX, 32'sh7fffffff);  // delete when empty
		send_item(CMD_NONE, 32'sh55555555);      // unused code, empty
		send_item(CMD_INSERT, 32'sh80000000);
		send_item(CMD_DEL_MIN, '0);             // delete of last key
		send_item(CMD_INSERT, 32'sh7fffffff);
		send_item(CMD_INSERT, 32'sh80000000);
		send_item(CMD_DEL_MAX, '0);             // max with two keys
		send_item(CMD_DEL_MAX, '0);             // delete of last key
		send_item(CMD_INSERT, 32'shffffffff);
		send_item(CMD_INSERT, 32'shffffffff);   // equal keys
		send_item(CMD_INSERT, 32'shffffffff);
		send_item(CMD_INSERT, '0);
		send_item(CMD_INSERT, 32'shaaaaaaaa);
		send_item(CMD_INSERT, 32'sh55555555);
		send_item(CMD_NONE, 32'shaaaaaaaa);      // unused code, loaded
		send_item(CMD_DEL_MIN, '0);
		send_item(CMD_DEL_MAX, '0);
		send_item(CMD_DEL_MIN, '0);
		send_item(CMD_DEL_MAX, '0);
		send_item(CMD_DEL_MIN, '0);
		send_item(CMD_DEL_MAX, '0);
		send_item(CMD_DEL_MIN, '0);             // empty again
		quiesce();
	endtask

	// fill to capacity, overflow, then sift deletes through the full depth
	task automatic test_full_heap();
		while (held < CAPACITY)
			send_item(CMD_INSERT, pick_key());
		send_item(CMD_INSERT, 32'sh12345678);
		send_item(CMD_INSERT, 32'sh80000000);
		quiesce();                              // pause until all reports are in
		send_item(CMD_DEL_MAX, '0);
		send_item(CMD_INSERT, $urandom);
		send_item(CMD_INSERT, $urandom);
		repeat (50)
			send_item($urandom_range(1) ? CMD_DEL_MAX : CMD_DEL_MIN, '0);
		quiesce();
	endtask

	// random mix: phases lean toward growth or shrinkage so depth varies
	task automatic test_random_mix(int unsigned n_items);
		int unsigned grow_pct;
		int unsigned pick;
		for (int unsigned i = 0; i < n_items; i++) begin
			if (i % 100 == 0)
				grow_pct = $urandom_range(80, 25);
			pick = $urandom_range(99);
			if (pick < 3)
				send_item(CMD_NONE, $urandom);
			else if (pick < grow_pct)
				send_item(CMD_INSERT, pick_key());
			else
				send_item($urandom_range(1) ? CMD_DEL_MAX : CMD_DEL_MIN, $urandom);
		end
		quiesce();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_NONE;
		key = '0;
		held = 0;
		failures = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_items();
		test_full_heap();
		test_random_mix(150);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending_reports.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog, far above the slowest correct run
	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### filelist.f
rtl/smmh_pkg.sv
rtl/symmetric_min_max_heap_unit.sv
sim/tb_top.sv
